>>> src/lsdp_pkg.sv
package lsdp_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int FILL_W      = ADDR_W + 1;
    localparam int KEY_W       = 64;
    localparam int NUM_CAP     = 4;
    localparam int CAP_W       = 9;
    localparam int MAX_BATCH   = 65536;
    localparam int CNT_W       = 17;
    localparam int EVICT_W     = 32;
    localparam int REG_IDX_W   = 3;
    localparam int DIST_W      = 8;

    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_CAP_0     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CAP_1     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CAP_2     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CAP_3     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KEY_LIMIT = 3'd4;

    typedef struct packed {
        logic                    command;
        logic signed [KEY_W-1:0] key;
        logic                    batch_last;
    } in_t;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic               cold_miss;
        logic [NUM_CAP-1:0] hit_mask;
        logic               removed_found;
        logic               batch_done;
        logic [CNT_W-1:0]   prefix_hits_0;
        logic [CNT_W-1:0]   prefix_hits_1;
        logic [CNT_W-1:0]   prefix_hits_2;
        logic [CNT_W-1:0]   prefix_hits_3;
        logic [CNT_W-1:0]   cold_prefix;
        logic [EVICT_W-1:0] evictions_total;
    } out_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic wr_carry;
        logic wr_shift;
        logic carry_adv;
        logic inc_idx;
        logic set_found;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic at_fill;
        logic match;
        logic is_remove;
        logic fill_full;
        logic out_busy;
    } ctrl_sts_t;

endpackage

>>> src/lsdp_ctrl.sv
module lsdp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lsdp_pkg::ctrl_sts_t   sts,
    output lsdp_pkg::ctrl_cmd_t   cmd
);
    import lsdp_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOOK = 6'b000010,
        ST_CMP  = 6'b000100,
        ST_SRD  = 6'b001000,
        ST_SWR  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (sts.at_fill) begin
                    // cold access lands at the bottom unless the stack is full
                    if (!sts.is_remove && !sts.fill_full) begin
                        cmd.wr_carry = 1'b1;
                    end
                    state_next = ST_FIN;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (!sts.is_remove) begin
                    cmd.wr_carry = 1'b1;
                    if (sts.match) begin
                        cmd.set_found = 1'b1;
                        state_next    = ST_FIN;
                    end else begin
                        cmd.carry_adv = 1'b1;
                        cmd.inc_idx   = 1'b1;
                        state_next    = ST_LOOK;
                    end
                end else begin
                    cmd.inc_idx = 1'b1;
                    if (sts.match) begin
                        cmd.set_found = 1'b1;
                        state_next    = ST_SRD;
                    end else begin
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_SRD: begin
                if (sts.at_fill) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_SWR;
                end
            end
            ST_SWR: begin
                cmd.wr_shift = 1'b1;
                cmd.inc_idx  = 1'b1;
                state_next   = ST_SRD;
            end
            ST_FIN: begin
                if (!sts.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/lsdp_datapath.sv
module lsdp_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lsdp_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output lsdp_pkg::out_t                  m_data,
    input  logic                            cfg_we,
    input  logic [lsdp_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [lsdp_pkg::CAP_W-1:0]      cfg_data,
    input  lsdp_pkg::ctrl_cmd_t             cmd,
    output lsdp_pkg::ctrl_sts_t             sts
);
    import lsdp_pkg::*;

    logic [KEY_W-1:0]   mem [STACK_DEPTH];
    logic [KEY_W-1:0]   rd_data_reg;

    logic [CAP_W-1:0]   cap_reg [NUM_CAP];
    logic [CAP_W-1:0]   key_limit_reg;

    logic               command_reg;
    logic               last_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   carry_reg;
    logic [FILL_W-1:0]  idx_reg;
    logic               found_reg;

    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [EVICT_W-1:0] evict_reg, evict_next;
    logic [NUM_CAP-1:0] open_reg, open_next;
    logic [CNT_W-1:0]   pcnt_reg [NUM_CAP];
    logic [CNT_W-1:0]   pcnt_next [NUM_CAP];
    logic               cold_seen_reg, cold_seen_next;
    logic [CNT_W-1:0]   cold_cnt_reg, cold_cnt_next;

    logic               m_valid_reg;
    out_t               out_reg, out_next;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [KEY_W-1:0]   mem_wdata;
    logic [FILL_W-1:0]  idx_dec;

    logic               cold;
    logic [FILL_W-1:0]  lim;
    logic [FILL_W-1:0]  f1;
    logic [NUM_CAP-1:0] hit;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v < CNT_W'(MAX_BATCH)) ? v + 1'b1 : v;
    endfunction

    assign idx_dec   = idx_reg - 1'b1;
    assign mem_we    = cmd.wr_carry || cmd.wr_shift;
    assign mem_waddr = cmd.wr_shift ? idx_dec[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign mem_wdata = cmd.wr_shift ? rd_data_reg : carry_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NUM_CAP; j++) begin
                cap_reg[j] <= '0;
            end
            key_limit_reg <= CAP_W'(STACK_DEPTH);
        end else if (cfg_we) begin
            if (cfg_index <= REG_CAP_3) begin
                cap_reg[cfg_index[1:0]] <= cfg_data;
            end else if (cfg_index == REG_KEY_LIMIT) begin
                key_limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            command_reg <= s_data.command;
            last_reg    <= s_data.batch_last;
            key_reg     <= s_data.key;
            carry_reg   <= s_data.key;
            idx_reg     <= '0;
            found_reg   <= 1'b0;
        end else begin
            if (cmd.carry_adv) begin
                carry_reg <= rd_data_reg;
            end
            if (cmd.inc_idx) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.set_found) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_comb begin
        cold = !found_reg;
        lim  = (key_limit_reg == '0 || key_limit_reg > CAP_W'(STACK_DEPTH))
               ? FILL_W'(STACK_DEPTH) : key_limit_reg;
        for (int j = 0; j < NUM_CAP; j++) begin
            hit[j] = !cold && (idx_reg < cap_reg[j]);
        end

        fill_next      = fill_reg;
        evict_next     = evict_reg;
        open_next      = open_reg;
        pcnt_next      = pcnt_reg;
        cold_seen_next = cold_seen_reg;
        cold_cnt_next  = cold_cnt_reg;
        out_next       = '0;
        f1             = fill_reg;

        if (command_reg == CMD_REMOVE) begin
            if (found_reg) begin
                fill_next  = fill_reg - 1'b1;
                evict_next = evict_reg + 1'b1;
            end
            out_next.removed_found = found_reg;
        end else begin
            if (cold) begin
                if (fill_reg == FILL_W'(STACK_DEPTH)) begin
                    evict_next = evict_reg + 1'b1;
                end else begin
                    f1 = fill_reg + 1'b1;
                end
            end
            // trim down to the limit, which may have been lowered
            if (f1 > lim) begin
                fill_next  = lim;
                evict_next = evict_next + EVICT_W'(f1 - lim);
            end else begin
                fill_next = f1;
            end

            for (int j = 0; j < NUM_CAP; j++) begin
                if (open_reg[j]) begin
                    if (hit[j]) begin
                        pcnt_next[j] = sat_inc(pcnt_reg[j]);
                    end else begin
                        open_next[j] = 1'b0;
                    end
                end
            end
            if (!cold_seen_reg) begin
                if (cold) begin
                    cold_seen_next = 1'b1;
                end else begin
                    cold_cnt_next = sat_inc(cold_cnt_reg);
                end
            end

            out_next.distance  = cold ? '0 : idx_reg[DIST_W-1:0];
            out_next.cold_miss = cold;
            out_next.hit_mask  = hit;
            if (last_reg) begin
                out_next.batch_done    = 1'b1;
                out_next.prefix_hits_0 = pcnt_next[0];
                out_next.prefix_hits_1 = pcnt_next[1];
                out_next.prefix_hits_2 = pcnt_next[2];
                out_next.prefix_hits_3 = pcnt_next[3];
                out_next.cold_prefix   = cold_cnt_next;
                open_next      = '1;
                cold_seen_next = 1'b0;
                cold_cnt_next  = '0;
                for (int j = 0; j < NUM_CAP; j++) begin
                    pcnt_next[j] = '0;
                end
            end
        end
        out_next.evictions_total = evict_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            evict_reg     <= '0;
            open_reg      <= '1;
            cold_seen_reg <= 1'b0;
            cold_cnt_reg  <= '0;
            for (int j = 0; j < NUM_CAP; j++) begin
                pcnt_reg[j] <= '0;
            end
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.finish) begin
                fill_reg      <= fill_next;
                evict_reg     <= evict_next;
                open_reg      <= open_next;
                cold_seen_reg <= cold_seen_next;
                cold_cnt_reg  <= cold_cnt_next;
                pcnt_reg      <= pcnt_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        sts.at_fill   = (idx_reg == fill_reg);
        sts.match     = (rd_data_reg == key_reg);
        sts.is_remove = (command_reg == CMD_REMOVE);
        sts.fill_full = (fill_reg == FILL_W'(STACK_DEPTH));
        sts.out_busy  = m_valid_reg && !m_ready;
    end

endmodule

>>> src/lru_stack_distance_profiler_core.sv
// an access reads and compares each entry from the top down, shifting it one place deeper,
//   until the key is found or the fill is reached; a remove scans to the key, then compacts the rest
// throughput: one request at a time, the next accepted once the controller is back in idle after the
//   result is registered; a result not yet taken holds the controller until it is
// reset: synchronous active-low aresetn empties the stack, clears batch and eviction
//   counters, capacities to 0 and key limit to 256; no clearing pass is needed
module lru_stack_distance_profiler_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  lsdp_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output lsdp_pkg::out_t                  m_data,
    input  logic                            cfg_we,
    input  logic [lsdp_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [lsdp_pkg::CAP_W-1:0]      cfg_data
);
    import lsdp_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    lsdp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lsdp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> verif/tb_lru_stack_distance_profiler_core.sv
`timescale 1ns / 1ps

import lsdp_pkg::*;

class lru_profile_board;
    logic [CAP_W-1:0] cap_reg [NUM_CAP];
    logic [CAP_W-1:0] limit_reg;
    logic [KEY_W-1:0] stack_q [$];
    int unsigned      batch_pos;
    bit               open_flag [NUM_CAP];
    int unsigned      hit_run [NUM_CAP];
    bit               cold_flag;
    int unsigned      cold_run;
    logic [EVICT_W-1:0] evict_cnt;
    out_t             pending_q [$];
    int unsigned      mismatches;
    int unsigned      results_seen;
    int unsigned      cold_total;
    int unsigned      batches_done;

    function new();
        foreach (cap_reg[j]) cap_reg[j] = '0;
        limit_reg = 9'd256;
        evict_cnt = '0;
        mismatches = 0;
        results_seen = 0;
        cold_total = 0;
        batches_done = 0;
        clear_batch();
    endfunction

    function void clear_batch();
        batch_pos = 0;
        foreach (open_flag[j]) begin
            open_flag[j] = 1'b1;
            hit_run[j] = 0;
        end
        cold_flag = 1'b0;
        cold_run = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CAP_W-1:0] val);
        if (idx <= REG_CAP_3) cap_reg[idx[1:0]] = val;
        else if (idx == REG_KEY_LIMIT) limit_reg = val;
    endfunction

    function int unsigned sat_up(int unsigned v);
        return (v < MAX_BATCH) ? v + 1 : v;
    endfunction

    function void note_request(in_t req);
        out_t exp_r;
        int pos;
        int unsigned lim;
        bit cold;
        bit hit;
        exp_r = '0;
        pos = -1;
        foreach (stack_q[i]) if (pos < 0 && stack_q[i] == req.key) pos = i;
        if (req.command == CMD_REMOVE) begin
            if (pos >= 0) begin
                stack_q.delete(pos);
                evict_cnt++;
                exp_r.removed_found = 1'b1;
            end
        end else begin
            cold = (pos < 0);
            if (cold) cold_total++;
            lim = (limit_reg == 0 || limit_reg > STACK_DEPTH) ? STACK_DEPTH : limit_reg;
            if (!cold) stack_q.delete(pos);
            stack_q.push_front(req.key);
            if (stack_q.size() > STACK_DEPTH) begin
                void'(stack_q.pop_back());
                evict_cnt++;
            end
            while (stack_q.size() > lim) begin
                void'(stack_q.pop_back());
                evict_cnt++;
            end
            batch_pos = sat_up(batch_pos);
            for (int j = 0; j < NUM_CAP; j++) begin
                hit = !cold && (pos < cap_reg[j]);
                if (hit) exp_r.hit_mask[j] = 1'b1;
                if (open_flag[j]) begin
                    if (hit) hit_run[j] = sat_up(hit_run[j]);
                    else open_flag[j] = 1'b0;
                end
            end
            if (!cold_flag) begin
                if (cold) cold_flag = 1'b1;
                else cold_run = sat_up(cold_run);
            end
            exp_r.distance = cold ? 8'd0 : (pos > 255 ? 8'd255 : pos[7:0]);
            exp_r.cold_miss = cold;
            if (req.batch_last) begin
                batches_done++;
                exp_r.batch_done = 1'b1;
                exp_r.prefix_hits_0 = CNT_W'(hit_run[0]);
                exp_r.prefix_hits_1 = CNT_W'(hit_run[1]);
                exp_r.prefix_hits_2 = CNT_W'(hit_run[2]);
                exp_r.prefix_hits_3 = CNT_W'(hit_run[3]);
                exp_r.cold_prefix = CNT_W'(cold_run);
                clear_batch();
            end
        end
        exp_r.evictions_total = evict_cnt;
        pending_q.push_back(exp_r);
    endfunction

    function void check_result(out_t got);
        out_t exp_r;
        results_seen++;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
        end
        exp_r = pending_q.pop_front();
        if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", exp_r, got);
        end
    endfunction
endclass

module tb_lru_stack_distance_profiler_core;
    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;
    logic cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CAP_W-1:0] cfg_data;

    lru_profile_board board;
    logic [KEY_W-1:0] key_pool [16];
    bit quiet_tail;
    bit long_hold;

    lru_stack_distance_profiler_core u_dut (.*);

    always begin
        aclk = 1'b1; #2;
        aclk = 1'b0; #2;
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
    end

    // receiver stalls; long hold-off lets the input back up
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
                long_hold = 1'b0;
            end
            if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // valid drops at the falling edge after acceptance, the block is busy well beyond that
    task automatic send_request(logic cmd, logic [KEY_W-1:0] k, logic last);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        s_data <= '{command: cmd, key: k, batch_last: last};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        board.note_request('{command: cmd, key: k, batch_last: last});
        @(negedge aclk);
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (board.pending_q.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (600) @(negedge aclk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CAP_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        board.write_reg(idx, val);
    endtask

    task automatic set_config(int unsigned c0, int unsigned c1, int unsigned c2,
                              int unsigned c3, int unsigned lim);
        write_reg(REG_CAP_0, CAP_W'(c0));
        write_reg(REG_CAP_1, CAP_W'(c1));
        write_reg(REG_CAP_2, CAP_W'(c2));
        write_reg(REG_CAP_3, CAP_W'(c3));
        write_reg(REG_KEY_LIMIT, CAP_W'(lim));
        cfg_we <= 1'b0;
    endtask

    // mostly reuse a small pool so hits happen, sometimes a fresh key
    function automatic logic [KEY_W-1:0] pick_key(int unsigned pool_n);
        if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
        return key_pool[$urandom_range(0, pool_n - 1)];
    endfunction

    task automatic random_phase(int unsigned n, int unsigned pool_n);
        for (int i = 0; i < n; i++)
            send_request($urandom_range(0, 7) == 0 ? CMD_REMOVE : CMD_ACCESS,
                         pick_key(pool_n), $urandom_range(0, 5) == 0);
    endtask

    initial begin
        board = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet_tail = 1'b0;
        long_hold = 1'b0;
        key_pool[0] = 64'h8000_0000_0000_0000;
        key_pool[1] = 64'h7fff_ffff_ffff_ffff;
        key_pool[2] = 64'h0;
        key_pool[3] = 64'hffff_ffff_ffff_ffff;
        for (int i = 4; i < 16; i++) key_pool[i] = {$urandom, $urandom};
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: extremes, cold/hit, removes, default limit 256
        send_request(CMD_ACCESS, key_pool[0], 1'b1);
        send_request(CMD_ACCESS, key_pool[1], 1'b0);
        send_request(CMD_ACCESS, key_pool[0], 1'b0);
        send_request(CMD_REMOVE, key_pool[2], 1'b1);
        send_request(CMD_ACCESS, key_pool[3], 1'b1);
        send_request(CMD_REMOVE, key_pool[1], 1'b0);
        drain();
        set_config(0, 1, 2, 256, 3);
        for (int i = 0; i < 4; i++) send_request(CMD_ACCESS, key_pool[i], 1'b0);
        send_request(CMD_ACCESS, key_pool[3], 1'b0);
        send_request(CMD_ACCESS, key_pool[2], 1'b0);
        send_request(CMD_ACCESS, key_pool[3], 1'b1);
        send_request(CMD_ACCESS, key_pool[3], 1'b1);
        send_request(CMD_ACCESS, key_pool[2], 1'b1);
        drain();
        set_config(256, 255, 1, 0, 1);
        send_request(CMD_ACCESS, key_pool[4], 1'b0);
        send_request(CMD_ACCESS, key_pool[4], 1'b0);
        send_request(CMD_ACCESS, key_pool[5], 1'b1);
        send_request(CMD_REMOVE, key_pool[5], 1'b0);
        drain();
        // full stack: fresh keys overflow 256 entries
        set_config(4, 64, 200, 256, 0);
        for (int i = 0; i < 270; i++) send_request(CMD_ACCESS, {$urandom, $urandom}, 1'b0);
        send_request(CMD_ACCESS, key_pool[6], 1'b1);
        drain();
        set_config(1, 3, 8, 16, 8);
        random_phase(250, 16);
        long_hold = 1'b1;
        random_phase(200, 16);
        drain();
        set_config(2, 5, 9, 14, 12);
        random_phase(200, 16);
        drain();
        set_config(0, 256, 300, 16, 257);
        random_phase(150, 12);
        drain();
        quiet_tail = 1'b1;
        set_config(3, 6, 10, 12, 16);
        random_phase(200, 16);
        drain();

        $display("covered %0d results, %0d cold misses, %0d batches, %0d evictions",
                 board.results_seen, board.cold_total, board.batches_done, board.evict_cnt);
        if (board.mismatches == 0 && board.pending_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d outstanding", board.mismatches,
                     board.pending_q.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

>>> filelist.f
src/lsdp_pkg.sv
src/lsdp_ctrl.sv
src/lsdp_datapath.sv
src/lru_stack_distance_profiler_core.sv
verif/tb_lru_stack_distance_profiler_core.sv
